>>> rtl/ggv_pkg.sv
// Shared types and constants for the go-to-goal velocity controller.
// Holds the CORDIC word layout, the limits bundle, register indexes and the arctangent table.
// No dependencies.
package ggv_pkg;

    localparam int XY_W        = 36;
    localparam int Z_W         = 34;
    localparam int GUARD_BITS  = 8;
    localparam int ERR_W       = 19;
    localparam int MAG_W       = 34;
    localparam int GAIN_W      = 24;
    localparam int PROD_W      = MAG_W + GAIN_W;
    localparam int DIST_W      = PROD_W - 32 + 1;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [Z_W-1:0]   PI_Z       = 34'sd1686629713;
    localparam logic signed [ERR_W-1:0] PI_Q13     = 19'sd25736;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 19'sd51472;
    localparam logic [GAIN_W-1:0]       INV_GAIN_Q24 = 24'd10188014;
    localparam logic [PROD_W:0]         ROUND_HALF   = (PROD_W+1)'(64'd1 << 31);
    localparam logic signed [Z_W-1:0]   Z_ROUND      = 34'sd32768;

    localparam logic [2:0] REG_TARGET_X      = 3'd0;
    localparam logic [2:0] REG_TARGET_Y      = 3'd1;
    localparam logic [2:0] REG_MAX_LINEAR    = 3'd2;
    localparam logic [2:0] REG_MAX_ANGULAR   = 3'd3;
    localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd4;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic signed [15:0]     heading;
    } ggv_vec_t;

    typedef struct packed {
        logic [15:0] max_linear;
        logic [14:0] max_angular;
        logic [15:0] arrive_radius;
    } ggv_limits_t;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            5'd0:    r = 34'sd421657428;
            5'd1:    r = 34'sd248918915;
            5'd2:    r = 34'sd131521918;
            5'd3:    r = 34'sd66762579;
            5'd4:    r = 34'sd33510843;
            5'd5:    r = 34'sd16771758;
            5'd6:    r = 34'sd8387925;
            5'd7:    r = 34'sd4194219;
            5'd8:    r = 34'sd2097141;
            5'd9:    r = 34'sd1048575;
            5'd10:   r = 34'sd524288;
            5'd11:   r = 34'sd262144;
            5'd12:   r = 34'sd131072;
            5'd13:   r = 34'sd65536;
            5'd14:   r = 34'sd32768;
            5'd15:   r = 34'sd16384;
            5'd16:   r = 34'sd8192;
            5'd17:   r = 34'sd4096;
            5'd18:   r = 34'sd2048;
            5'd19:   r = 34'sd1024;
            5'd20:   r = 34'sd512;
            5'd21:   r = 34'sd256;
            5'd22:   r = 34'sd128;
            5'd23:   r = 34'sd64;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/ggv_front.sv
// Front stage: goal offset with guard bits and the half-plane pre-rotation.
// Depends on ggv_pkg.
module ggv_front
    import ggv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] heading,
    input  logic signed [23:0] target_x,
    input  logic signed [23:0] target_y,
    output logic               out_valid,
    output ggv_vec_t           out_vec
);

    logic signed [24:0]     dx;
    logic signed [24:0]     dy;
    logic signed [XY_W-1:0] x_ext;
    logic signed [XY_W-1:0] y_ext;
    logic                   valid_reg;
    ggv_vec_t               vec_reg;
    ggv_vec_t               vec_next;

    assign dx = $signed({target_x[23], target_x}) - $signed({pos_x[23], pos_x});
    assign dy = $signed({target_y[23], target_y}) - $signed({pos_y[23], pos_y});
    assign x_ext = $signed({{(XY_W-25-GUARD_BITS){dx[24]}}, dx, {GUARD_BITS{1'b0}}});
    assign y_ext = $signed({{(XY_W-25-GUARD_BITS){dy[24]}}, dy, {GUARD_BITS{1'b0}}});

    // A goal with a negative x offset is turned by pi so the CORDIC starts in the right half-plane.
    always_comb begin
        vec_next.heading = heading;
        if (dx[24]) begin
            vec_next.x = -x_ext;
            vec_next.y = -y_ext;
            vec_next.z = dy[24] ? -PI_Z : PI_Z;
        end else begin
            vec_next.x = x_ext;
            vec_next.y = y_ext;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

>>> rtl/ggv_cordic_stage.sv
// One registered vectoring CORDIC micro-rotation with a fixed shift.
// Depends on ggv_pkg for the word layout and the arctangent table.
module ggv_cordic_stage
    import ggv_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  ggv_vec_t in_vec,
    output logic     out_valid,
    output ggv_vec_t out_vec
);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  angle;
    logic                   valid_reg;
    ggv_vec_t               vec_reg;
    ggv_vec_t               vec_next;

    assign xs    = in_vec.x >>> STEP;
    assign ys    = in_vec.y >>> STEP;
    assign angle = atan_lut(5'(STEP));

    always_comb begin
        vec_next.heading = in_vec.heading;
        if (!in_vec.y[XY_W-1]) begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + angle;
        end else begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

>>> rtl/ggv_back.sv
// Back end: gain correction, arrival test, speed cap, angle wrap and clamp.
// Three register stages, the last of which is the result register. Depends on ggv_pkg.
module ggv_back
    import ggv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  ggv_vec_t           in_vec,
    input  ggv_limits_t        limits,
    output logic               out_valid,
    output logic [15:0]        linear_speed,
    output logic signed [15:0] angular_speed,
    output logic               arrived
);

    // Stage one: product and raw angle error.
    logic                    s1_valid_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [PROD_W-1:0]       prod_next;
    logic signed [ERR_W-1:0] err1_reg;
    logic signed [ERR_W-1:0] err1_next;
    logic signed [Z_W-1:0]   z_round;

    // Stage two: distance decisions and wrapped error.
    logic                    s2_valid_reg;
    logic [15:0]             lin_reg;
    logic [15:0]             lin_next;
    logic                    arr_reg;
    logic                    arr_next;
    logic signed [ERR_W-1:0] err2_reg;
    logic signed [ERR_W-1:0] err2_next;
    logic [PROD_W:0]         prod_rnd;
    logic [DIST_W-1:0]       distance;

    // Stage three: result register.
    logic                    out_valid_reg;
    logic [15:0]             lin_out_reg;
    logic signed [15:0]      ang_out_reg;
    logic signed [15:0]      ang_next;
    logic                    arr_out_reg;
    logic signed [ERR_W-1:0] lim;

    assign prod_next = PROD_W'(in_vec.x[MAG_W-1:0]) * PROD_W'(INV_GAIN_Q24);
    assign z_round   = in_vec.z + Z_ROUND;
    assign err1_next = ERR_W'($signed(z_round[Z_W-1:16]))
                     - ERR_W'(in_vec.heading);

    assign prod_rnd = {1'b0, prod_reg} + ROUND_HALF;
    assign distance = prod_rnd[PROD_W:32];
    assign arr_next = distance < DIST_W'(limits.arrive_radius);
    assign lin_next = (distance > DIST_W'(limits.max_linear)) ? limits.max_linear
                                                              : distance[15:0];

    always_comb begin
        logic signed [ERR_W-1:0] e;
        e = err1_reg;
        for (int k = 0; k < 2; k++) begin
            if (e > PI_Q13) begin
                e = e - TWO_PI_Q13;
            end else if (e < -PI_Q13) begin
                e = e + TWO_PI_Q13;
            end
        end
        err2_next = e;
    end

    assign lim = $signed({{(ERR_W-15){1'b0}}, limits.max_angular});

    always_comb begin
        if (err2_reg > lim) begin
            ang_next = lim[15:0];
        end else if (err2_reg < -lim) begin
            ang_next = 16'(-lim);
        end else begin
            ang_next = err2_reg[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= prod_next;
            err1_reg    <= err1_next;
            lin_reg     <= lin_next;
            arr_reg     <= arr_next;
            err2_reg    <= err2_next;
            lin_out_reg <= arr_reg ? 16'd0 : lin_reg;
            ang_out_reg <= arr_reg ? 16'sd0 : ang_next;
            arr_out_reg <= arr_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign linear_speed  = lin_out_reg;
    assign angular_speed = ang_out_reg;
    assign arrived       = arr_out_reg;

endmodule

>>> rtl/go_to_goal_velocity_controller.sv
// Top level of the go-to-goal velocity controller: configuration registers and pipeline.
// Depends on ggv_pkg, ggv_front, ggv_cordic_stage and ggv_back.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    s_pos_x, s_pos_y, s_heading
//   m_        out        m_valid / m_ready    m_linear_speed, m_angular_speed, m_arrived
//   cfg_      in         cfg_we               cfg_index, cfg_data
//
// One word enters per cycle while m_ready does not stall the pipeline, which holds one register
// per CORDIC micro-rotation plus the front stage and three back-end stages.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// A stall on m_ready freezes the whole pipeline, and s_ready falls with it.
module go_to_goal_velocity_controller
    import ggv_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_pos_x,
    input  logic signed [23:0] s_pos_y,
    input  logic signed [15:0] s_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_linear_speed,
    output logic signed [15:0] m_angular_speed,
    output logic               m_arrived,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    logic signed [23:0] target_x_reg;
    logic signed [23:0] target_y_reg;
    logic [15:0]        max_linear_reg;
    logic [14:0]        max_angular_reg;
    logic [15:0]        arrive_radius_reg;
    ggv_limits_t        limits;
    logic               adv;

    logic               valid_chain [CORDIC_STEPS+1];
    ggv_vec_t           vec_chain   [CORDIC_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg      <= '0;
            target_y_reg      <= '0;
            max_linear_reg    <= 16'd3277;
            max_angular_reg   <= 15'd20480;
            arrive_radius_reg <= 16'd655;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TARGET_X:      target_x_reg      <= $signed(cfg_data);
                REG_TARGET_Y:      target_y_reg      <= $signed(cfg_data);
                REG_MAX_LINEAR:    max_linear_reg    <= cfg_data[15:0];
                REG_MAX_ANGULAR:   max_angular_reg   <= cfg_data[14:0];
                REG_ARRIVE_RADIUS: arrive_radius_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign limits.max_linear    = max_linear_reg;
    assign limits.max_angular   = max_angular_reg;
    assign limits.arrive_radius = arrive_radius_reg;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    ggv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .pos_x     (s_pos_x),
        .pos_y     (s_pos_y),
        .heading   (s_heading),
        .target_x  (target_x_reg),
        .target_y  (target_y_reg),
        .out_valid (valid_chain[0]),
        .out_vec   (vec_chain[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        ggv_cordic_stage #(
            .STEP (g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (valid_chain[g]),
            .in_vec    (vec_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_vec   (vec_chain[g+1])
        );
    end

    ggv_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (adv),
        .in_valid      (valid_chain[CORDIC_STEPS]),
        .in_vec        (vec_chain[CORDIC_STEPS]),
        .limits        (limits),
        .out_valid     (m_valid),
        .linear_speed  (m_linear_speed),
        .angular_speed (m_angular_speed),
        .arrived       (m_arrived)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for go_to_goal_velocity_controller: directed and random pose words checked
// against an in-bench fixed-point predictor of the CORDIC steering law. Depends on ggv_pkg.
module tb;
    import ggv_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam logic [2:0] REG_SPARE = 3'd7;

    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;
    localparam longint ANGLE_PI = 64'sd1686629713;
    localparam longint HEAD_PI = 64'sd25736;
    localparam longint HEAD_TWO_PI = 64'sd51472;
    localparam longint unsigned GAIN_FIX = 64'd10188014;

    typedef struct packed {
        logic [15:0]        lin;
        logic signed [15:0] ang;
        logic               arr;
    } velocity_cmd_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [23:0] s_pos_x;
    logic signed [23:0] s_pos_y;
    logic signed [15:0] s_heading;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_linear_speed;
    logic signed [15:0] m_angular_speed;
    logic               m_arrived;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;

    logic signed [23:0] goal_x;
    logic signed [23:0] goal_y;
    logic [15:0]        speed_cap;
    logic [14:0]        turn_cap;
    logic [15:0]        arrive_r;

    velocity_cmd_t pending_cmds[$];
    longint atan_steps[24] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096,
        2048, 1024, 512, 256, 128, 64
    };

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int words_sent = 0;
    int cmds_checked = 0;
    int arrivals = 0;
    int goal_settings = 0;

    go_to_goal_velocity_controller #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_heading      (s_heading),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_linear_speed (m_linear_speed),
        .m_angular_speed(m_angular_speed),
        .m_arrived      (m_arrived),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic velocity_cmd_t steer_toward_goal(input logic signed [23:0] px,
                                                        input logic signed [23:0] py,
                                                        input logic signed [15:0] hd);
        velocity_cmd_t r;
        longint x, y, z, xs, ys, bearing, err, lim;
        longint unsigned distance;
        x = (longint'(goal_x) - longint'(px)) * 256;
        y = (longint'(goal_y) - longint'(py)) * 256;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? ANGLE_PI : -ANGLE_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_steps[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_steps[i];
            end
        end
        distance = (longint'(unsigned'(x)) * GAIN_FIX + 64'd2147483648) >> 32;
        if (distance < longint'(arrive_r)) begin
            r.lin = '0;
            r.ang = '0;
            r.arr = 1'b1;
            return r;
        end
        bearing = (z + 32768) >>> 16;
        err = bearing - longint'(hd);
        for (int i = 0; i < 2; i++) begin
            if (err > HEAD_PI) begin
                err = err - HEAD_TWO_PI;
            end else if (err < -HEAD_PI) begin
                err = err + HEAD_TWO_PI;
            end
        end
        lim = longint'(turn_cap);
        if (err > lim) err = lim;
        if (err < -lim) err = -lim;
        r.lin = (distance > longint'(speed_cap)) ? speed_cap : distance[15:0];
        r.ang = err[15:0];
        r.arr = 1'b0;
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TARGET_X:      goal_x = data;
            REG_TARGET_Y:      goal_y = data;
            REG_MAX_LINEAR:    speed_cap = data[15:0];
            REG_MAX_ANGULAR:   turn_cap = data[14:0];
            REG_ARRIVE_RADIUS: arrive_r = data[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_pose(input logic signed [23:0] px, input logic signed [23:0] py,
                             input logic signed [15:0] hd);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_pos_x <= px;
        s_pos_y <= py;
        s_heading <= hd;
        do @(posedge aclk); while (!s_ready);
        pending_cmds.push_back(steer_toward_goal(px, py, hd));
        words_sent++;
    endtask

    task automatic wait_drained();
        if (s_valid) s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        velocity_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                fail_count++;
                $error("command word with no pose outstanding");
            end else begin
                want = pending_cmds.pop_front();
                cmds_checked++;
                if (want.arr) arrivals++;
                if (m_linear_speed !== want.lin) begin
                    fail_count++;
                    $error("linear_speed: expected %0d, got %0d", want.lin, m_linear_speed);
                end
                if (m_angular_speed !== want.ang) begin
                    fail_count++;
                    $error("angular_speed: expected %0d, got %0d", want.ang,
                           m_angular_speed);
                end
                if (m_arrived !== want.arr) begin
                    fail_count++;
                    $error("arrived: expected %0d, got %0d", want.arr, m_arrived);
                end
            end
        end
    end

    task automatic test_reset_values();
        send_pose(24'sd0, 24'sd0, 16'sd0);
        send_pose(-24'sd655360, 24'sd0, 16'sd0);
        send_pose(24'sd0, -24'sd655360, 16'sd25736);
        wait_drained();
    endtask

    task automatic test_zero_offset();
        write_reg(REG_ARRIVE_RADIUS, 24'd0);
        write_reg(REG_TARGET_X, 24'sd1000);
        write_reg(REG_TARGET_Y, -24'sd1000);
        send_pose(24'sd1000, -24'sd1000, 16'sd0);
        send_pose(24'sd1000, -24'sd1000, -16'sd32768);
        wait_drained();
    endtask

    task automatic test_extremes();
        write_reg(REG_MAX_LINEAR, 24'hFFFFFF);
        write_reg(REG_TARGET_X, POS_MAX);
        write_reg(REG_TARGET_Y, POS_MIN);
        send_pose(POS_MIN, POS_MAX, 16'sd32767);
        send_pose(POS_MAX, POS_MIN, 16'sd0);
        wait_drained();
        write_reg(REG_TARGET_X, POS_MIN);
        write_reg(REG_TARGET_Y, POS_MAX);
        send_pose(POS_MAX, POS_MIN, -16'sd32768);
        send_pose(POS_MAX, POS_MAX, 16'sd0);
        wait_drained();
        write_reg(REG_TARGET_Y, 24'sd0);
        send_pose(POS_MAX, 24'sd1, 16'sd0);
        wait_drained();
    endtask

    task automatic test_wrap_and_clamp();
        write_reg(REG_TARGET_X, 24'sd0);
        write_reg(REG_TARGET_Y, 24'sd0);
        write_reg(REG_MAX_ANGULAR, 24'hFFFFFF);
        write_reg(REG_MAX_LINEAR, 24'd0);
        send_pose(24'sd3000000, 24'sd10, 16'sd32767);
        send_pose(24'sd3000000, -24'sd10, -16'sd32767);
        send_pose(-24'sd3000000, 24'sd5, 16'sd25736);
        send_pose(24'sd5, -24'sd3000000, -16'sd25737);
        wait_drained();
        write_reg(REG_MAX_ANGULAR, 24'd0);
        send_pose(24'sd200000, 24'sd900000, 16'sd12000);
        wait_drained();
        write_reg(REG_MAX_ANGULAR, 24'd25736);
        send_pose(24'sd200000, -24'sd900000, 16'sd25737);
        wait_drained();
    endtask

    task automatic test_register_masking();
        write_reg(REG_SPARE, 24'h123456);
        write_reg(REG_ARRIVE_RADIUS, 24'hFFFFFF);
        send_pose(24'sd30000, -24'sd30000, 16'sd100);
        wait_drained();
        write_reg(REG_ARRIVE_RADIUS, 24'hA5028F);
        write_reg(REG_MAX_LINEAR, 24'h5A7FFF);
        send_pose(POS_MIN, POS_MIN, 16'sd0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++) begin
            send_pose(24'($urandom), 24'($urandom), 16'($urandom));
        end
        wait_drained();
        for (int i = 0; i < 12; i++) begin
            send_pose(24'($urandom), 24'($urandom), 16'($urandom));
        end
        wait_drained();
    endtask

    task automatic pick_goal_setting();
        logic [23:0] val;
        int sel;
        sel = $urandom_range(99);
        val = (sel < 70) ? 24'($urandom) : (sel < 85) ? ($urandom_range(1) ? POS_MAX : POS_MIN)
                                                      : 24'd0;
        write_reg(REG_TARGET_X, val);
        sel = $urandom_range(99);
        val = (sel < 70) ? 24'($urandom) : (sel < 85) ? ($urandom_range(1) ? POS_MAX : POS_MIN)
                                                      : 24'd0;
        write_reg(REG_TARGET_Y, val);
        case ($urandom_range(3))
            0: val = 24'd0;
            1: val = 24'd65535;
            2: val = 24'($urandom_range(4000));
            default: val = 24'($urandom_range(65535));
        endcase
        write_reg(REG_MAX_LINEAR, {8'($urandom), val[15:0]});
        case ($urandom_range(3))
            0: val = 24'd0;
            1: val = 24'd25736;
            2: val = 24'($urandom_range(25736));
            default: val = 24'($urandom_range(32767));
        endcase
        write_reg(REG_MAX_ANGULAR, {9'($urandom), val[14:0]});
        case ($urandom_range(3))
            0: val = 24'd0;
            1: val = 24'd65535;
            2: val = 24'($urandom_range(2000));
            default: val = 24'($urandom_range(65535));
        endcase
        write_reg(REG_ARRIVE_RADIUS, {8'($urandom), val[15:0]});
        if ($urandom_range(3) == 0) begin
            write_reg(3'(REG_ARRIVE_RADIUS + $urandom_range(1, 3)), 24'($urandom));
        end
        goal_settings++;
    endtask

    task automatic test_random_poses(input int count, input int src_pct, input int snk_pct);
        logic signed [23:0] px, py;
        logic signed [15:0] hd;
        int off_x, off_y, mag;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 90 == 0) begin
                wait_drained();
                pick_goal_setting();
            end
            if ($urandom_range(99) < 80) begin
                mag = $urandom_range(23, 0);
                off_x = $signed($urandom) >>> (31 - mag);
                off_y = $signed($urandom) >>> (31 - mag);
                px = 24'(longint'(goal_x) - off_x);
                py = 24'(longint'(goal_y) - off_y);
            end else begin
                px = 24'($urandom);
                py = 24'($urandom);
            end
            if ($urandom_range(99) < 85) begin
                hd = 16'(int'($urandom_range(51472)) - 25736);
            end else begin
                hd = 16'($urandom);
            end
            send_pose(px, py, hd);
        end
        wait_drained();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_pos_x <= '0;
        s_pos_y <= '0;
        s_heading <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        goal_x = '0;
        goal_y = '0;
        speed_cap = 16'd3277;
        turn_cap = 15'd20480;
        arrive_r = 16'd655;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_zero_offset();
        test_extremes();
        test_wrap_and_clamp();
        test_register_masking();
        test_backpressure();
        test_random_poses(520, 14, 59);
        test_random_poses(520, 59, 14);
        test_random_poses(520, 0, 0);

        wait_drained();
        repeat (CORDIC_STEPS + 20) @(posedge aclk);
        $display("Sent %0d pose words, checked %0d commands (%0d arrivals).",
                 words_sent, cmds_checked, arrivals);
        $display("Covered %0d random goal settings, directed extremes and a long output stall.",
                 goal_settings);
        if (fail_count == 0 && pending_cmds.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
